@@ sv/bfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the best-fit block allocator.
// No dependencies; imported by bfa_cell and the top level.
package bfa_pkg;

    localparam int CFG_W   = 5;   // block_count register width
    localparam int IDX_W   = 4;   // block_index / chosen_block field width
    localparam int FIELD_W = 16;  // size_value / fragmentation field width

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = CFG_W'(16);

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   block_index;
        logic [FIELD_W-1:0] size_value;
    } t_bfa_in;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   chosen_block;
        logic [FIELD_W-1:0] fragmentation;
    } t_bfa_out;

endpackage

@@ sv/bfa_cell.sv @@
`timescale 1ns / 1ps
// One table cell: holds a block size and its taken mark, and passes the
// best-fit candidate on to the next cell. Depends on bfa_pkg.
module bfa_cell #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_BITS  = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bfa_pkg::CFG_W-1:0]  i_count,
    input  logic [SIZE_BITS-1:0]       i_req,
    input  logic                       i_wr_en,
    input  logic [IDX_BITS-1:0]        i_wr_idx,
    input  logic [SIZE_BITS-1:0]       i_wr_size,
    input  logic                       i_take_en,
    input  logic [IDX_BITS-1:0]        i_take_idx,
    input  logic                       i_have,
    input  logic [IDX_BITS-1:0]        i_idx,
    input  logic [SIZE_BITS-1:0]       i_size,
    output logic                       o_have,
    output logic [IDX_BITS-1:0]        o_idx,
    output logic [SIZE_BITS-1:0]       o_size
);
    import bfa_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_taken;
    logic                 r_have;
    logic [IDX_BITS-1:0]  r_idx;
    logic [SIZE_BITS-1:0] r_best;
    logic                 in_range;
    logic                 fits;
    logic                 better;

    assign in_range = 32'(i_count) > CELL_IDX;
    assign fits     = in_range && !r_taken && (r_size >= i_req);
    // strict compare keeps the lower index on a tie
    assign better   = fits && (!i_have || (r_size < i_size));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
        end else if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_taken <= 1'b0;
        end else if (i_take_en && (i_take_idx == MY_IDX)) begin
            r_taken <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_size <= i_wr_size;
        end
    end

    // hand the candidate to the neighbor every cycle
    always_ff @(posedge i_clk) begin
        if (better) begin
            r_have <= 1'b1;
            r_idx  <= MY_IDX;
            r_best <= r_size;
        end else begin
            r_have <= i_have;
            r_idx  <= i_idx;
            r_best <= i_size;
        end
    end

    assign o_have = r_have;
    assign o_idx  = r_idx;
    assign o_size = r_best;

endmodule

@@ sv/best_fit_block_allocator_top.sv @@
`timescale 1ns / 1ps
// Best-fit block allocator: a row of MAX_BLOCKS cells, each holding one block.
// Load: writes the cell, gives no result and leaves busy low; the next item may start in the following cycle.
// Request: the candidate travels through the row one cell per cycle, so the
// result strobes once it has left the last cell; busy stays high until then.
// Sync active-low reset clears taken marks, busy and sets block_count to 16;
// block sizes are undefined until loaded. The receiver cannot stall results.
module best_fit_block_allocator_top #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  bfa_pkg::t_bfa_in              i_item,
    // result channel
    output logic                          o_valid,
    output bfa_pkg::t_bfa_out             o_result,
    // configuration channel (block_count)
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]     i_cfg_data
);
    import bfa_pkg::*;

    localparam int IW    = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // control state
    logic                 r_busy;
    logic                 r_valid;
    logic [CNT_W-1:0]     r_cnt;
    logic [CFG_W-1:0]     r_block_count;
    // payload
    logic [SIZE_BITS-1:0] r_req;
    t_bfa_out             r_result;

    logic                 accept;
    logic                 is_req;
    logic                 idx_ok;
    logic                 load_en;
    logic                 done;
    logic                 take_en;
    logic [IW-1:0]        load_idx;
    logic [SIZE_BITS-1:0] in_size;
    t_bfa_out             n_result;

    // candidate chain between cells; entry 0 feeds the first cell
    logic                 chain_have [0:MAX_BLOCKS];
    logic [IW-1:0]        chain_idx  [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0] chain_size [0:MAX_BLOCKS];

    assign accept   = start && !r_busy;
    assign is_req   = (i_item.kind == KIND_REQUEST);
    assign idx_ok   = 32'(i_item.block_index) < MAX_BLOCKS;
    assign load_idx = IW'(i_item.block_index);
    assign in_size  = SIZE_BITS'(i_item.size_value);
    assign load_en  = accept && !is_req && idx_ok;

    // the candidate has passed every cell when the count reaches the row length
    assign done     = r_busy && (r_cnt == CNT_W'(MAX_BLOCKS));
    assign take_en  = done && chain_have[MAX_BLOCKS];

    assign chain_have[0] = 1'b0;
    assign chain_idx[0]  = '0;
    assign chain_size[0] = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        bfa_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IDX_BITS  (IW),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_block_count),
            .i_req      (r_req),
            .i_wr_en    (load_en),
            .i_wr_idx   (load_idx),
            .i_wr_size  (in_size),
            .i_take_en  (take_en),
            .i_take_idx (chain_idx[MAX_BLOCKS]),
            .i_have     (chain_have[g]),
            .i_idx      (chain_idx[g]),
            .i_size     (chain_size[g]),
            .o_have     (chain_have[g+1]),
            .o_idx      (chain_idx[g+1]),
            .o_size     (chain_size[g+1])
        );
    end

    // build the result from the candidate leaving the last cell
    always_comb begin
        n_result = '0;
        if (chain_have[MAX_BLOCKS]) begin
            n_result.found         = 1'b1;
            n_result.chosen_block  = IDX_W'(chain_idx[MAX_BLOCKS]);
            n_result.fragmentation = FIELD_W'(chain_size[MAX_BLOCKS] - r_req);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_valid       <= 1'b0;
            r_cnt         <= '0;
            r_block_count <= BLOCK_COUNT_RESET;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_block_count <= i_cfg_data;
            end
            if (accept && is_req) begin
                // hold busy while the candidate walks the row
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (done) begin
                // drop busy and strobe the result
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_req) begin
            r_req <= in_size;
        end
        if (done) begin
            r_result <= n_result;
        end
    end

    assign busy        = r_busy;
    assign o_valid     = r_valid;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule
